>>> design/r2h_pkg.sv
// Shared types, constants and the divider step function for the RGB to HSV converter.
`timescale 1ns / 1ps

package r2h_pkg;

  // Hue resolution and the derived sector scale.
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_SCALE     = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;

  // Internal hue arithmetic width, wide enough for the full circle at this resolution.
  localparam int HUE_CALC_W = 18;

  // Divider geometry: 24-bit dividend, 8-bit divisor, 16 quotient bits.
  localparam int DIV_STEPS = 16;
  localparam int DEN_W     = 8;
  localparam int DVD_W     = DEN_W + DIV_STEPS;

  // Output field widths.
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;
  localparam int CH_W  = 8;

  // Sector that holds the largest channel.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel control carried alongside the two divisions.
  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              hue_zero;
    logic              sat_zero;
    logic [CH_W-1:0]   bright;
  } side_t;

  // One lane of the restoring divider: partial remainder, dividend/quotient word, divisor.
  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [DIV_STEPS-1:0] work;
    logic [DEN_W-1:0]     den;
  } lane_t;

  // Starts a lane from a dividend that is known to be below den << DIV_STEPS.
  function automatic lane_t lane_init(input logic [DVD_W-1:0] dvd, input logic [DEN_W-1:0] den);
    lane_t l;
    l.rem  = dvd[DVD_W-1:DIV_STEPS];
    l.work = dvd[DIV_STEPS-1:0];
    l.den  = den;
    return l;
  endfunction

  // One restoring step: bring down the next dividend bit and shift in one quotient bit.
  function automatic lane_t lane_step(input lane_t l);
    lane_t          o;
    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    logic           ge;
    t  = {l.rem, l.work[DIV_STEPS-1]};
    d  = {1'b0, l.den};
    ge = (t >= d);
    o.rem  = ge ? DEN_W'(t - d) : t[DEN_W-1:0];
    o.work = {l.work[DIV_STEPS-2:0], ge};
    o.den  = l.den;
    return o;
  endfunction

endpackage

>>> design/r2h_front.sv
// Front stages: channel extremes and sector selection, then dividend formation.
`timescale 1ns / 1ps

module r2h_front
  import r2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] in_pixel_word,
  output logic        valid_o,
  output side_t       side_o,
  output lane_t       sat_o,
  output lane_t       hue_o
);

  logic [CH_W-1:0] r, g, b;
  logic [CH_W-1:0] mx, mn, pos, negv;
  sector_t         sec;

  logic            s1_valid_r;
  side_t           s1_side_r, s1_side_nxt;
  logic [CH_W-1:0] s1_delta_r, s1_delta_nxt;
  logic [CH_W-1:0] s1_num_r, s1_num_nxt;

  logic            s2_valid_r;
  side_t           s2_side_r;
  lane_t           s2_sat_r, s2_sat_nxt;
  lane_t           s2_hue_r, s2_hue_nxt;

  logic [DVD_W-1:0] sat_dvd;
  logic [DVD_W-1:0] hue_dvd;

  // Largest and smallest channel, with red over green over blue on ties.
  always_comb begin
    r   = in_pixel_word[31:24];
    g   = in_pixel_word[23:16];
    b   = in_pixel_word[15:8];
    mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    if (mx == r) begin
      sec  = SEC_RED;
      pos  = g;
      negv = b;
    end else if (mx == g) begin
      sec  = SEC_GREEN;
      pos  = b;
      negv = r;
    end else begin
      sec  = SEC_BLUE;
      pos  = r;
      negv = g;
    end
    s1_delta_nxt         = mx - mn;
    s1_num_nxt           = (pos >= negv) ? (pos - negv) : (negv - pos);
    s1_side_nxt.sector   = sec;
    s1_side_nxt.neg      = (pos < negv);
    s1_side_nxt.hue_zero = (mx == mn);
    s1_side_nxt.sat_zero = (mx == '0);
    s1_side_nxt.bright   = mx;
  end

  // Dividends: delta * 65535 for saturation and num * scale for hue.
  always_comb begin
    sat_dvd    = {s1_delta_r, {DIV_STEPS{1'b0}}} - DVD_W'(s1_delta_r);
    hue_dvd    = DVD_W'(s1_num_r) * DVD_W'(HUE_SCALE);
    s2_sat_nxt = lane_init(sat_dvd, s1_side_r.bright);
    s2_hue_nxt = lane_init(hue_dvd, s1_delta_r);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= s1_side_nxt;
      s1_delta_r <= s1_delta_nxt;
      s1_num_r   <= s1_num_nxt;
      s2_side_r  <= s1_side_r;
      s2_sat_r   <= s2_sat_nxt;
      s2_hue_r   <= s2_hue_nxt;
    end
  end

  assign valid_o = s2_valid_r;
  assign side_o  = s2_side_r;
  assign sat_o   = s2_sat_r;
  assign hue_o   = s2_hue_r;

endmodule

>>> design/r2h_div.sv
// Pipelined restoring divider: two lanes, one quotient bit per stage.
`timescale 1ns / 1ps

module r2h_div
  import r2h_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  valid_i,
  input  side_t side_i,
  input  lane_t sat_i,
  input  lane_t hue_i,
  output logic  valid_o,
  output side_t side_o,
  output lane_t sat_o,
  output lane_t hue_o
);

  logic  valid_r [DIV_STEPS];
  side_t side_r  [DIV_STEPS];
  lane_t sat_r   [DIV_STEPS];
  lane_t hue_r   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic  v_src;
    side_t s_src;
    lane_t sat_src;
    lane_t hue_src;

    // Each stage takes from the one before it, the first from the front end.
    if (k == 0) begin : g_first
      assign v_src   = valid_i;
      assign s_src   = side_i;
      assign sat_src = sat_i;
      assign hue_src = hue_i;
    end else begin : g_next
      assign v_src   = valid_r[k-1];
      assign s_src   = side_r[k-1];
      assign sat_src = sat_r[k-1];
      assign hue_src = hue_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= s_src;
        sat_r[k]  <= lane_step(sat_src);
        hue_r[k]  <= lane_step(hue_src);
      end
    end
  end

  assign valid_o = valid_r[DIV_STEPS-1];
  assign side_o  = side_r[DIV_STEPS-1];
  assign sat_o   = sat_r[DIV_STEPS-1];
  assign hue_o   = hue_r[DIV_STEPS-1];

endmodule

>>> design/r2h_back.sv
// Back stage: hue sector offset and wrap, special cases, and the output register.
`timescale 1ns / 1ps

module r2h_back
  import r2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             valid_i,
  input  side_t            side_i,
  input  lane_t            sat_i,
  input  lane_t            hue_i,
  output logic             out_valid,
  output logic [HUE_W-1:0] out_hue,
  output logic [SAT_W-1:0] out_saturation,
  output logic [CH_W-1:0]  out_brightness
);

  logic                  valid_r;
  logic [HUE_W-1:0]      hue_r, hue_nxt;
  logic [SAT_W-1:0]      sat_r, sat_nxt;
  logic [CH_W-1:0]       bright_r;
  logic [HUE_CALC_W-1:0] q;
  logic [HUE_CALC_W-1:0] base;
  logic [HUE_CALC_W-1:0] hue_full;

  // Apply the sector base and the sign of the quotient.
  always_comb begin
    q = HUE_CALC_W'(hue_i.work);
    unique case (side_i.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_CALC_W'(2 * HUE_SCALE);
      SEC_BLUE:  base = HUE_CALC_W'(4 * HUE_SCALE);
      default:   base = '0;
    endcase
    if (!side_i.neg) begin
      hue_full = base + q;
    end else if (side_i.sector == SEC_RED) begin
      // A negative red hue wraps around the circle, unless it truncated to zero.
      hue_full = (q == '0) ? '0 : HUE_CALC_W'(HUE_FULL) - q;
    end else begin
      hue_full = base - q;
    end
    hue_nxt = side_i.hue_zero ? '0 : hue_full[HUE_W-1:0];
    sat_nxt = side_i.sat_zero ? '0 : sat_i.work;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= side_i.bright;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

>>> design/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: front end, bit-per-stage divider and back end.
//
//  channel   direction  handshake           payload
//  in_       input      in_valid/in_stall   in_pixel_word[31:0]
//  out_      output     out_valid/out_stall out_hue[14:0], out_saturation[15:0],
//                                           out_brightness[7:0]
//
// One pixel is accepted every cycle while the output is not stalled; each result
// passes through two front stages, sixteen divider stages (one quotient bit each)
// and the output register. Reset clears only the stage valid bits; there is
// no state between pixels. A stalled output freezes the whole pipeline, so
// in_stall follows out_stall while a result is waiting; nothing is dropped
// or repeated.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit
  import r2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_pixel_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HUE_W-1:0] out_hue,
  output logic [SAT_W-1:0] out_saturation,
  output logic [CH_W-1:0]  out_brightness
);

  logic  adv;
  logic  f_valid, d_valid;
  side_t f_side, d_side;
  lane_t f_sat, f_hue, d_sat, d_hue;

  // The pipeline moves unless a finished result is held by the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  r2h_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_pixel_word (in_pixel_word),
    .valid_o       (f_valid),
    .side_o        (f_side),
    .sat_o         (f_sat),
    .hue_o         (f_hue)
  );

  r2h_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (f_valid),
    .side_i  (f_side),
    .sat_i   (f_sat),
    .hue_i   (f_hue),
    .valid_o (d_valid),
    .side_o  (d_side),
    .sat_o   (d_sat),
    .hue_o   (d_hue)
  );

  r2h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .valid_i        (d_valid),
    .side_i         (d_side),
    .sat_i          (d_sat),
    .hue_i          (d_hue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule

>>> design/r2h_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps

module r2h_checker
  import r2h_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [31:0]      in_pixel_word,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HUE_W-1:0] out_hue,
  input logic [SAT_W-1:0] out_saturation,
  input logic [CH_W-1:0]  out_brightness
);

  // A held result stays in place until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue) && $stable(out_saturation)
      && $stable(out_brightness))
    else $error("held result changed");

  // The input is only stalled while a result is waiting at the output.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Hue stays inside one turn of the circle.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_hue) < 32'(HUE_FULL))
    else $error("hue out of range");

  // A black pixel has no saturation and no hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation means a grey pixel, whose hue is zero.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == '0 |-> out_hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_unit r2h_checker u_r2h_checker (.*);

>>> tb/rgb_to_hsv_converter_unit_tb.sv
// Self-checking testbench for the RGB to HSV converter unit.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit_tb;
  import r2h_pkg::*;

  // One converted pixel as it appears on the result channel.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  bright;
  } hsv_t;

  // Holds the HSV values that accepted pixels must produce, in order.
  class HsvScoreboard;
    localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
    localparam int unsigned CIRCLE_SPAN = 360 << HUE_FRAC_BITS;
    localparam int PRINT_CAP = 30;

    hsv_t hsv_queue[$];
    int   errors;
    int   noted;
    int   checked;

    function new();
      errors  = 0;
      noted   = 0;
      checked = 0;
    endfunction

    function int pending();
      return hsv_queue.size();
    endfunction

    // Integer HSV of one packed pixel word; the low byte plays no part.
    function hsv_t convert(logic [31:0] word);
      int unsigned r, g, b, mx, mn, dl, base, pos, neg, q, hue_v, sat_v;
      sector_t     sec;
      hsv_t        res;
      r = 32'(word[31:24]);
      g = 32'(word[23:16]);
      b = 32'(word[15:8]);
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      dl = mx - mn;
      hue_v = 0;
      sat_v = 0;
      if (mx != 0) begin
        sat_v = dl * 65535 / mx;
        if (dl != 0) begin
          // Ties for the maximum go to red first, then green.
          if (mx == r) sec = SEC_RED;
          else if (mx == g) sec = SEC_GREEN;
          else sec = SEC_BLUE;
          case (sec)
            SEC_RED: begin
              base = 0;
              pos  = g;
              neg  = b;
            end
            SEC_GREEN: begin
              base = 2 * SECTOR_SPAN;
              pos  = b;
              neg  = r;
            end
            default: begin
              base = 4 * SECTOR_SPAN;
              pos  = r;
              neg  = g;
            end
          endcase
          // The quotient magnitude is truncated before its sign is applied.
          if (pos >= neg) begin
            hue_v = base + SECTOR_SPAN * (pos - neg) / dl;
          end else begin
            q = SECTOR_SPAN * (neg - pos) / dl;
            if (base == 0) hue_v = (q == 0) ? 0 : CIRCLE_SPAN - q;
            else hue_v = base - q;
          end
        end
      end
      res.hue    = hue_v[HUE_W-1:0];
      res.sat    = sat_v[SAT_W-1:0];
      res.bright = mx[CH_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [31:0] word);
      hsv_queue.push_back(convert(word));
      noted++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compares one accepted result with the oldest outstanding pixel.
    task check_result(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat, logic [CH_W-1:0] bright);
      hsv_t exp_hsv;
      if (hsv_queue.size() == 0) begin
        report($sformatf("result hue %0d sat %0d value %0d with no pixel outstanding",
                         hue, sat, bright));
        return;
      end
      exp_hsv = hsv_queue.pop_front();
      checked++;
      if (hue !== exp_hsv.hue)
        report($sformatf("hue %0d, expected %0d", hue, exp_hsv.hue));
      if (sat !== exp_hsv.sat)
        report($sformatf("saturation %0d, expected %0d", sat, exp_hsv.sat));
      if (bright !== exp_hsv.bright)
        report($sformatf("brightness %0d, expected %0d", bright, exp_hsv.bright));
    endtask
  endclass

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 80;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [31:0]      in_pixel_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_saturation;
  logic [CH_W-1:0]  out_brightness;

  HsvScoreboard sb;
  bit           steady = 1'b0;
  bit           long_hold_req = 1'b0;
  int           idle_cycles = 0;

  rgb_to_hsv_converter_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_word (in_pixel_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness)
  );

  always #5 clk = ~clk;

  // Check every result transaction against the oldest outstanding pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_hue, out_saturation, out_brightness);
  end

  // End the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[%0t] Watchdog: no transaction for %0d cycles, %0d pixels outstanding",
               $time, IDLE_LIMIT, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the steady phase.
  initial begin
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Random pixel: plain words, near-grey colors, tied maxima and extreme channels.
  function automatic logic [31:0] random_pixel();
    logic [7:0] ch[3];
    logic [7:0] lo;
    int         k, t, base, top;
    lo = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        // Small delta around a random level stresses the hue divider.
        base = $urandom_range(0, 255);
        for (k = 0; k < 3; k++) begin
          t = base + int'($urandom_range(0, 6)) - 3;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          ch[k] = 8'(t);
        end
      end
      7: begin
        // Two channels share the maximum.
        top = $urandom_range(1, 255);
        for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, top));
        k = $urandom_range(0, 2);
        ch[k] = 8'(top);
        ch[(k + 1) % 3] = 8'(top);
      end
      default: begin
        for (k = 0; k < 3; k++) begin
          case ($urandom_range(0, 4))
            0: ch[k] = 8'd0;
            1: ch[k] = 8'd1;
            2: ch[k] = 8'd254;
            3: ch[k] = 8'd255;
            default: ch[k] = 8'($urandom);
          endcase
        end
      end
    endcase
    return {ch[0], ch[1], ch[2], lo};
  endfunction

  // Offers one pixel, with an occasional gap before it, and waits for its transaction.
  task automatic send_pixel(input logic [31:0] word);
    if (!steady && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_word <= word;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(word);
  endtask

  // Stops offering pixels until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Stimulus: directed corners, random bulk, a long output hold, then a steady stream.
  initial begin
    static logic [31:0] corner_px[24] = '{
      32'h00000000, 32'hFFFFFFFF, 32'h000000FF, 32'h80808000,
      32'h01010100, 32'hFF000000, 32'h00FF0000, 32'h0000FF00,
      32'hFFFF0000, 32'h00FFFF00, 32'hFF00FF00, 32'hFFFFFF00,
      32'hFF000100, 32'hFF010000, 32'h0AC80000, 32'h00C80A00,
      32'h0A00C800, 32'h000AC800, 32'h01000000, 32'h01000100,
      32'hFFFE0000, 32'hFE00FF00, 32'h7F80817E, 32'hA5C3E1FF
    };
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_px[i]) send_pixel(corner_px[i]);
    repeat (400) send_pixel(random_pixel());

    // Hold the output long enough that the pipeline fills and stalls its input.
    long_hold_req = 1'b1;
    repeat (60) send_pixel(random_pixel());
    drain_results();

    repeat (580) send_pixel(random_pixel());

    // Back-to-back pixels with no stalls on either side.
    steady = 1'b1;
    repeat (150) send_pixel(random_pixel());
    drain_results();
    repeat (40) @(posedge clk);

    $display("Sent %0d pixels: black, grey, tied maxima, hue wrap and extreme channels,",
             sb.noted);
    $display("plus random and near-grey words; %0d results checked under random stalls.",
             sb.checked);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
